@@ design/vfd_pkg.sv @@
// Shared types and widths for the varint frame deframer.
package vfd_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned VAL_W   = 62;
	localparam int unsigned TDATA_W = 136;
	localparam int unsigned TUSER_W = 2;

	// One deframed result as it sits in the queue and the output register.
	typedef struct packed {
		logic [BYTE_W-1:0] payload_byte;
		logic              byte_valid;
		logic              to_server;
		logic [VAL_W-1:0]  stream_position;
		logic [VAL_W-1:0]  frame_length;
		logic              last_of_frame;
	} result_t;

	// Handshake between the parser and the queue.
	typedef struct packed {
		logic    push;
		result_t item;
	} push_t;

endpackage

@@ design/varint_frame_deframer_unit.sv @@
// Top level of the varint frame deframer: parser, result queue, output register.
//
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid / s_tready  s_tdata: framed stream byte
//  m_*       out  m_tvalid / m_tready  m_tdata, m_tuser, m_tlast: payload byte results
//  cfg_*     in   cfg_we               cfg_wdata: reserve threshold
//
// One byte is taken per cycle while the queue is not full; header bytes give
// no transfer, payload bytes give one each, an empty data frame gives one with no byte.
// A result is written into the queue, then into the output register, before it shows on m_*.
// s_tready drops only when the QUEUE_DEPTH-entry queue is full, so a stalled
// master side backs up the queue first; the parser never stops on its own.
// Reset clears parser state, threshold (to zero), queue pointers and m_tvalid.
module varint_frame_deframer_unit #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration
	input  logic                        cfg_we,
	input  logic [vfd_pkg::VAL_W-1:0]   cfg_wdata,    // reserve_threshold
	// input stream
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [vfd_pkg::BYTE_W-1:0]  s_tdata,      // [7:0] data_byte
	// result stream
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// [7:0] payload_byte, [69:8] stream_position, [131:70] frame_length, rest zero
	output logic [vfd_pkg::TDATA_W-1:0] m_tdata,
	output logic [vfd_pkg::TUSER_W-1:0] m_tuser,      // [0] byte_valid, [1] to_server
	output logic                        m_tlast       // last_of_frame
);
	import vfd_pkg::*;

	push_t   push;
	result_t q_head;
	logic    q_full;
	logic    q_not_empty;
	logic    q_pop;
	logic    byte_take;

	// every byte pushes at most one result, so a free slot is all we need
	assign s_tready  = !q_full;
	assign byte_take = s_tvalid && s_tready;

	vfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.byte_take (byte_take),
		.byte_in   (s_tdata),
		.push      (push)
	);

	vfd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (q_full),
		.not_empty (q_not_empty),
		.pop       (q_pop),
		.head      (q_head)
	);

	vfd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);

endmodule

@@ design/vfd_front.sv @@
// Header parser: walks offset and length varints, classifies frames, tags payload bytes.
module vfd_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [vfd_pkg::VAL_W-1:0]  cfg_wdata,
	input  logic                       byte_take,
	input  logic [vfd_pkg::BYTE_W-1:0] byte_in,
	output vfd_pkg::push_t             push
);
	import vfd_pkg::*;

	localparam logic [1:0] PH_OFFSET  = 2'd0;
	localparam logic [1:0] PH_LENGTH  = 2'd1;
	localparam logic [1:0] PH_PAYLOAD = 2'd2;

	logic [VAL_W-1:0] threshold_q;
	logic [1:0]       phase_q, phase_d;
	logic [2:0]       left_q, left_d;
	logic [VAL_W-1:0] acc_q, acc_d;
	logic [VAL_W-1:0] offset_q, offset_d;
	logic [VAL_W-1:0] pos_q, pos_d;
	logic [VAL_W-1:0] remain_q, remain_d;
	logic [VAL_W-1:0] total_q, total_d;
	logic             is_data_q, is_data_d;
	logic             vdone;
	logic [VAL_W:0]   diff;

	// borrow out of offset - threshold means control frame
	assign diff = {1'b0, offset_q} - {1'b0, threshold_q};

	always_comb begin
		phase_d   = phase_q;
		left_d    = left_q;
		acc_d     = acc_q;
		offset_d  = offset_q;
		pos_d     = pos_q;
		remain_d  = remain_q;
		total_d   = total_q;
		is_data_d = is_data_q;
		push      = '0;

		// varint byte feed
		if (left_q == 3'd0) begin
			acc_d = {{(VAL_W-6){1'b0}}, byte_in[5:0]};
			unique case (byte_in[7:6])
				2'd0:    left_d = 3'd0;
				2'd1:    left_d = 3'd1;
				2'd2:    left_d = 3'd3;
				default: left_d = 3'd7;
			endcase
		end else begin
			acc_d  = {acc_q[VAL_W-9:0], byte_in};
			left_d = left_q - 3'd1;
		end
		vdone = (left_d == 3'd0);

		unique case (phase_q)
			PH_PAYLOAD: begin
				left_d                    = left_q;
				acc_d                     = acc_q;
				push.push                 = byte_take;
				push.item.payload_byte    = byte_in;
				push.item.byte_valid      = 1'b1;
				push.item.to_server       = is_data_q;
				push.item.stream_position = pos_q;
				push.item.frame_length    = total_q;
				push.item.last_of_frame   = (remain_q == {{(VAL_W-1){1'b0}}, 1'b1});
				pos_d    = pos_q + {{(VAL_W-1){1'b0}}, 1'b1};
				remain_d = remain_q - {{(VAL_W-1){1'b0}}, 1'b1};
				if (push.item.last_of_frame)
					phase_d = PH_OFFSET;
			end
			PH_LENGTH: begin
				if (vdone) begin
					total_d   = acc_d;
					remain_d  = acc_d;
					is_data_d = !diff[VAL_W];
					pos_d     = diff[VAL_W] ? offset_q : diff[VAL_W-1:0];
					if (acc_d != '0) begin
						phase_d = PH_PAYLOAD;
					end else begin
						phase_d = PH_OFFSET;
						// empty data frame still reports its position
						push.push                 = byte_take && !diff[VAL_W];
						push.item.to_server       = 1'b1;
						push.item.stream_position = pos_d;
						push.item.last_of_frame   = 1'b1;
					end
				end
			end
			default: begin
				// offset varint; the unused code falls back here too
				phase_d = PH_OFFSET;
				if (vdone) begin
					offset_d = acc_d;
					phase_d  = PH_LENGTH;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= '0;
			phase_q     <= PH_OFFSET;
			left_q      <= '0;
			acc_q       <= '0;
			offset_q    <= '0;
			pos_q       <= '0;
			remain_q    <= '0;
			total_q     <= '0;
			is_data_q   <= 1'b0;
		end else begin
			if (cfg_we)
				threshold_q <= cfg_wdata;
			if (byte_take) begin
				phase_q   <= phase_d;
				left_q    <= left_d;
				acc_q     <= acc_d;
				offset_q  <= offset_d;
				pos_q     <= pos_d;
				remain_q  <= remain_d;
				total_q   <= total_d;
				is_data_q <= is_data_d;
			end
		end
	end

endmodule

@@ design/vfd_queue.sv @@
// Small result queue between parser and output stage.
module vfd_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  vfd_pkg::push_t    push,
	output logic              full,
	output logic              not_empty,
	input  logic              pop,
	output vfd_pkg::result_t  head
);
	import vfd_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	result_t          slot_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full      = (cnt_q == FULL_CNT);
	assign not_empty = (cnt_q != '0);
	assign do_push   = push.push && !full;
	assign do_pop    = pop && not_empty;
	assign head      = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_q] <= push.item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + PTR_W'(1);
			if (do_pop)
				rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + PTR_W'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

endmodule

@@ design/vfd_back.sv @@
// Output register stage: drains the queue onto the master stream.
module vfd_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_not_empty,
	input  vfd_pkg::result_t            q_head,
	output logic                        q_pop,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [vfd_pkg::TDATA_W-1:0] m_tdata,
	output logic [vfd_pkg::TUSER_W-1:0] m_tuser,
	output logic                        m_tlast
);
	import vfd_pkg::*;

	logic    valid_q;
	result_t out_q;

	assign q_pop    = q_not_empty && (!valid_q || m_tready);
	assign m_tvalid = valid_q;
	assign m_tdata  = {{(TDATA_W - BYTE_W - 2*VAL_W){1'b0}}, out_q.frame_length,
		out_q.stream_position, out_q.payload_byte};
	assign m_tuser  = {out_q.to_server, out_q.byte_valid};
	assign m_tlast  = out_q.last_of_frame;

	always_ff @(posedge clk) begin
		if (q_pop)
			out_q <= q_head;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (q_pop)
			valid_q <= 1'b1;
		else if (m_tready)
			valid_q <= 1'b0;
	end

endmodule

@@ design/vfd_checker.sv @@
// Port-level checks for the varint frame deframer, bound to the top level.
module vfd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [vfd_pkg::TDATA_W-1:0] m_tdata,
	input logic [vfd_pkg::TUSER_W-1:0] m_tuser,
	input logic                        m_tlast
);

	// held result does not change while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
		&& $stable(m_tlast))
		else $error("result changed under stall");

	// an empty result only comes from a data frame and closes it
	a_empty_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tlast && m_tuser[1])
		else $error("empty result not a last data transfer");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[7:0] == 8'd0 && m_tdata[131:70] == 62'd0)
		else $error("empty result carries byte or length");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[135:132] == 4'd0)
		else $error("tdata pad bits set");

endmodule

bind varint_frame_deframer_unit vfd_checker u_vfd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

@@ bench/vfd_deframe_checker.sv @@
// Checker for the varint frame deframer: tracks the byte stream, predicts results, compares.
module vfd_deframe_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [vfd_pkg::VAL_W-1:0]   cfg_wdata,
	input  logic                        s_tvalid,
	input  logic                        s_tready,
	input  logic [vfd_pkg::BYTE_W-1:0]  s_tdata,
	input  logic                        m_tvalid,
	input  logic                        m_tready,
	input  logic [vfd_pkg::TDATA_W-1:0] m_tdata,
	input  logic [vfd_pkg::TUSER_W-1:0] m_tuser,
	input  logic                        m_tlast,
	output int unsigned                 mismatches,
	output int unsigned                 due_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import vfd_pkg::*;

	localparam int unsigned POS_LSB = BYTE_W;
	localparam int unsigned LEN_LSB = BYTE_W + VAL_W;
	localparam int unsigned PAD_LSB = BYTE_W + 2 * VAL_W;

	typedef enum logic [1:0] {
		PH_OFFSET,
		PH_LENGTH,
		PH_PAYLOAD
	} parse_phase_t;

	// tracked parser state
	parse_phase_t       phase;
	logic [2:0]         varint_left;
	logic [VAL_W-1:0]   varint_acc;
	logic [VAL_W-1:0]   hdr_offset;
	logic [VAL_W-1:0]   position;
	logic [VAL_W-1:0]   bytes_left;
	logic [VAL_W-1:0]   frame_len;
	logic               is_data;
	logic [VAL_W-1:0]   threshold;

	result_t            results_due[$];

	// one byte into the varint reader; done when the value is complete
	task automatic feed_varint(input logic [BYTE_W-1:0] b, output logic done);
		if (varint_left == 3'd0) begin
			varint_acc  = VAL_W'(b[5:0]);
			varint_left = 3'((1 << b[7:6]) - 1);
		end else begin
			varint_acc  = {varint_acc[VAL_W-9:0], b};
			varint_left = varint_left - 3'd1;
		end
		done = (varint_left == 3'd0);
	endtask

	task automatic deframe_byte(input logic [BYTE_W-1:0] b);
		result_t r;
		logic    done;
		r = '0;
		case (phase)
			PH_PAYLOAD: begin
				r.payload_byte    = b;
				r.byte_valid      = 1'b1;
				r.to_server       = is_data;
				r.stream_position = position;
				r.frame_length    = frame_len;
				r.last_of_frame   = (bytes_left == VAL_W'(1));
				results_due = {results_due, r};
				position   = position + VAL_W'(1);
				bytes_left = bytes_left - VAL_W'(1);
				if (bytes_left == '0)
					phase = PH_OFFSET;
			end
			PH_LENGTH: begin
				feed_varint(b, done);
				if (done) begin
					frame_len  = varint_acc;
					bytes_left = varint_acc;
					// threshold is taken here, not when the offset arrived
					is_data  = (hdr_offset >= threshold);
					position = is_data ? hdr_offset - threshold : hdr_offset;
					if (varint_acc != '0) begin
						phase = PH_PAYLOAD;
					end else begin
						phase = PH_OFFSET;
						// empty data frame still reports its position; empty control is silent
						if (is_data) begin
							r.to_server       = 1'b1;
							r.stream_position = position;
							r.last_of_frame   = 1'b1;
							results_due = {results_due, r};
						end
					end
				end
			end
			default: begin
				phase = PH_OFFSET;
				feed_varint(b, done);
				if (done) begin
					hdr_offset = varint_acc;
					phase      = PH_LENGTH;
				end
			end
		endcase
	endtask

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_result();
		result_t want;
		if (results_due.size() == 0) begin
			$error("result transfer with nothing expected: tdata 0x%0h", m_tdata);
			mismatches++;
		end else begin
			want = results_due.pop_front();
			compare_field("payload_byte", 64'(want.payload_byte), 64'(m_tdata[BYTE_W-1:0]));
			compare_field("byte_valid", 64'(want.byte_valid), 64'(m_tuser[0]));
			compare_field("to_server", 64'(want.to_server), 64'(m_tuser[1]));
			compare_field("stream_position", 64'(want.stream_position),
				64'(m_tdata[POS_LSB +: VAL_W]));
			compare_field("frame_length", 64'(want.frame_length),
				64'(m_tdata[LEN_LSB +: VAL_W]));
			compare_field("last_of_frame", 64'(want.last_of_frame), 64'(m_tlast));
			compare_field("tdata_pad", 64'd0, 64'(m_tdata[TDATA_W-1:PAD_LSB]));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase       = PH_OFFSET;
			varint_left = '0;
			varint_acc  = '0;
			hdr_offset  = '0;
			position    = '0;
			bytes_left  = '0;
			frame_len   = '0;
			is_data     = 1'b0;
			threshold   = '0;
			results_due.delete();
			mismatches  = 0;
			due_count   = 0;
		end else begin
			// a result passes the queue and the output register before it shows, so check before predicting
			if (m_tvalid && m_tready)
				check_result();
			if (cfg_we)
				threshold = cfg_wdata;
			if (s_tvalid && s_tready)
				deframe_byte(s_tdata);
			due_count = results_due.size();
		end
	end

endmodule

@@ bench/varint_frame_deframer_unit_test.sv @@
// Testbench top for the varint frame deframer: clock, reset, stimulus and verdict.
module varint_frame_deframer_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import vfd_pkg::*;

	localparam logic [VAL_W-1:0] MAX62       = '1;
	localparam int unsigned      RANDOM_BYTES = 1850;
	localparam int unsigned      SEGMENTS     = 6;
	// run bound, set far above the slowest case with both sides idling
	localparam int unsigned      CYCLE_LIMIT  = 400000;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               cfg_we    = 1'b0;
	logic [VAL_W-1:0]   cfg_wdata = '0;
	logic               s_tvalid  = 1'b0;
	logic               s_tready;
	logic [BYTE_W-1:0]  s_tdata   = '0;
	logic               m_tvalid;
	logic               m_tready  = 1'b0;
	logic [TDATA_W-1:0] m_tdata;
	logic [TUSER_W-1:0] m_tuser;
	logic               m_tlast;

	int unsigned        mismatches;
	int unsigned        due_count;

	// idle percentages for sender gaps and receiver stalls
	int unsigned        send_idle   = 0;
	int unsigned        recv_stall  = 0;
	int unsigned        bytes_sent  = 0;
	int unsigned        cycle_count = 0;
	logic [VAL_W-1:0]   reserve_now = '0;

	varint_frame_deframer_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	vfd_deframe_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.mismatches(mismatches),
		.due_count (due_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// run guard: a hang anywhere ends here
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("varint_frame_deframer_unit test failed");
			$finish;
		end
	end

	// receiver side: random stalls, one update per falling edge
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall);
	end

	// One byte transfer. Called and returns at a falling edge; tvalid is left high so
	// back-to-back bytes keep it up without a glitch.
	task automatic push_byte(input logic [BYTE_W-1:0] b);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		bytes_sent++;
	endtask

	// Drop tvalid and wait until every predicted result has been taken.
	task automatic hold_and_drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (due_count != 0)
			@(negedge clk);
	endtask

	// Threshold write with the input held and every predicted result drained first.
	task automatic set_threshold(input logic [VAL_W-1:0] value);
		hold_and_drain();
		repeat (4) @(negedge clk);
		cfg_we      <= 1'b1;
		cfg_wdata   <= value;
		reserve_now  = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [1:0] shortest_code(input logic [VAL_W-1:0] value);
		if (value < 64'd64)
			return 2'd0;
		if (value < 64'd16384)
			return 2'd1;
		if (value < 64'd1073741824)
			return 2'd2;
		return 2'd3;
	endfunction

	// Big-endian varint; the size tag sits in the top two bits of the first byte.
	// With stretch set a longer-than-needed encoding may be picked.
	task automatic send_varint(input logic [VAL_W-1:0] value, input bit stretch);
		logic [1:0]  code;
		logic [63:0] word;
		int          n;
		code = shortest_code(value);
		if (stretch)
			code = 2'($urandom_range(3, code));
		n    = 1 << code;
		word = 64'(value) | (64'(code) << (8 * n - 2));
		for (int i = n - 1; i >= 0; i--)
			push_byte(word[8 * i +: 8]);
	endtask

	function automatic logic [VAL_W-1:0] rand62();
		return VAL_W'({$urandom, $urandom});
	endfunction

	// Offsets cluster around the current threshold so both frame kinds and the
	// boundary itself come up often; a few sit at the top to force position wrap.
	function automatic logic [VAL_W-1:0] pick_offset();
		logic [VAL_W:0] sum;
		case ($urandom_range(9))
			0, 1, 2: begin
				sum = {1'b0, reserve_now} + (VAL_W + 1)'($urandom_range(50));
				return sum[VAL_W] ? MAX62 : sum[VAL_W-1:0];
			end
			3:       return reserve_now;
			4:       return (reserve_now != '0) ? reserve_now - VAL_W'(1) : '0;
			5, 6:    return VAL_W'($urandom_range(300));
			7:       return rand62();
			8:       return MAX62 - VAL_W'($urandom_range(7));
			default: return rand62() >> $urandom_range(61);
		endcase
	endfunction

	task automatic send_random_frame();
		logic [VAL_W-1:0] len;
		len = ($urandom_range(9) == 0) ? VAL_W'($urandom_range(7, 40))
		                               : VAL_W'($urandom_range(6));
		send_varint(pick_offset(), 1'($urandom_range(1)));
		send_varint(len, 1'($urandom_range(1)));
		for (int i = 0; i < int'(len); i++)
			push_byte(8'($urandom));
		// now and then the sender waits for the result side to empty
		if ($urandom_range(59) == 0)
			hold_and_drain();
	endtask

	initial begin
		logic [VAL_W-1:0] seg_threshold;
		int unsigned      seg_end;

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// ---- directed part ----
		recv_stall = 30;

		// reset threshold is zero: an empty frame at offset 0 is data
		push_byte(8'h00);
		push_byte(8'h00);

		set_threshold(VAL_W'(100));

		// control frame, payload at both byte extremes
		push_byte(8'h05);
		push_byte(8'h02);
		push_byte(8'h00);
		push_byte(8'hFF);

		// empty control frame: nothing comes out
		push_byte(8'h07);
		push_byte(8'h00);

		// empty data frame right at the threshold, two-byte offset
		push_byte(8'h40);
		push_byte(8'h64);
		push_byte(8'h00);

		// eight-byte offset at the top of the range, one payload byte
		repeat (8) push_byte(8'hFF);
		push_byte(8'h01);
		push_byte(8'hAA);

		// threshold moved between offset and length: 100 is now below it -> control
		push_byte(8'h40);
		push_byte(8'h64);
		set_threshold(VAL_W'(101));
		push_byte(8'h80);
		push_byte(8'h00);
		push_byte(8'h00);
		push_byte(8'h01);
		push_byte(8'h3C);

		// ---- random part ----
		// segments pair up on idle patterns: sender light / receiver heavy,
		// then swapped, then no idling at all
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg)
				0:       seg_threshold = '0;
				1:       seg_threshold = MAX62;
				2:       seg_threshold = rand62();
				3:       seg_threshold = VAL_W'($urandom_range(1, 200));
				4:       seg_threshold = rand62() >> $urandom_range(61);
				default: seg_threshold = '0;
			endcase
			case (seg / 2)
				0: begin
					send_idle  = 22;
					recv_stall = 56;
				end
				1: begin
					send_idle  = 56;
					recv_stall = 22;
				end
				default: begin
					send_idle  = 0;
					recv_stall = 0;
				end
			endcase
			set_threshold(seg_threshold);
			seg_end = bytes_sent + RANDOM_BYTES / SEGMENTS;
			while (bytes_sent < seg_end)
				send_random_frame();
		end

		// stream ends inside a frame with the largest length: never marked last
		send_varint(rand62(), 1'b1);
		send_varint(MAX62, 1'b0);
		repeat (6) push_byte(8'($urandom));

		hold_and_drain();
		repeat (8) @(negedge clk);

		if (mismatches == 0)
			$display("varint_frame_deframer_unit test passed");
		else
			$display("varint_frame_deframer_unit test failed");
		$finish;
	end

endmodule
